@@ rtl/i2p_pkg.sv @@
`default_nettype none

package i2p_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Operator codes as held on the stack; bit 1 set means high precedence.
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_OPERAND,
        S_OPER,
        S_FLUSH
    } t_state;

    function automatic logic is_op(input logic [7:0] ch);
        return ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    endfunction

    function automatic t_op op_of(input logic [7:0] ch);
        t_op op;
        case (ch)
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default:  op = OP_ADD;
        endcase
        return op;
    endfunction

    function automatic logic [7:0] char_of(input t_op op);
        logic [7:0] ch;
        case (op)
            OP_SUB:  ch = CH_MINUS;
            OP_MUL:  ch = CH_STAR;
            OP_DIV:  ch = CH_SLASH;
            default: ch = CH_PLUS;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ rtl/i2p_stack.sv @@
`default_nettype none

module i2p_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  wire                               i_clk,
    input  wire                               i_we,
    input  wire  [$clog2(STACK_DEPTH)-1:0]    i_waddr,
    input  wire  i2p_pkg::t_op                i_wdata,
    input  wire  [$clog2(STACK_DEPTH)-1:0]    i_raddr,
    output i2p_pkg::t_op                      o_rdata
);

    i2p_pkg::t_op r_mem [STACK_DEPTH];
    i2p_pkg::t_op r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Forward a write to the entry being read in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/infix_to_postfix_converter.sv @@
// Flow: a beat is taken only in the idle state, so the converter takes no new beat until it is
// through with the last one. An operand goes to the output register; an operator first pops each
// stacked entry of equal or higher precedence, then is pushed; an end-flagged beat then drains the
// stack. Each result waits while o_valid is held by a low i_ready.
// Reset (i_rst_n low, synchronous): empty stack, cleared overflow flag, no result pending.
// The stack memory holds no reset; only entries below the count are ever used.
`default_nettype none

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // input channel
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [7:0] i_symbol,
    input  wire        i_end_of_expr,
    // result channel
    output logic       o_valid,
    input  wire        i_ready,
    output logic [7:0] o_out_symbol,
    output logic       o_expr_last,
    output logic       o_overflow
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Control state
    i2p_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf_seen, n_ovf_seen;
    logic            r_out_valid, n_out_valid;

    // Held input beat
    logic [7:0]      r_sym, n_sym;
    logic            r_last, n_last;
    i2p_pkg::t_op    r_code, n_code;

    // Output register
    logic [7:0]      r_out_sym, n_out_sym;
    logic            r_out_last, n_out_last;
    logic            r_out_ovf, n_out_ovf;

    // Stack memory access
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [AW-1:0]   w_raddr;
    logic [CW-1:0]   w_top_idx;
    i2p_pkg::t_op    w_top;

    logic            w_slot_free;
    logic            w_pop_cond;
    logic            w_full;

    i2p_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_code),
        .i_raddr (w_raddr),
        .o_rdata (w_top)
    );

    // The output register takes a new result when empty or being drained.
    assign w_slot_free = !r_out_valid || i_ready;

    // Pop while the top has equal or higher precedence: a low-precedence
    // operator pops anything, a high-precedence one only * and /.
    assign w_pop_cond = (r_count != '0) && (!r_code[1] || w_top[1]);
    assign w_full     = (r_count == CW'(STACK_DEPTH));

    // Push lands at the current count.
    assign w_waddr    = r_count[AW-1:0];

    // Keep the memory reading the entry that will be on top next cycle,
    // so its registered output always shows the current top.
    assign w_top_idx  = n_count - CW'(1);
    assign w_raddr    = w_top_idx[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf_seen  = r_ovf_seen;
        n_sym       = r_sym;
        n_last      = r_last;
        n_code      = r_code;
        n_out_valid = r_out_valid && !i_ready;
        n_out_sym   = r_out_sym;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        w_we        = 1'b0;

        case (r_state)
            i2p_pkg::S_IDLE: begin
                // Capture the beat and route it by kind.
                if (i_valid) begin
                    n_sym  = i_symbol;
                    n_last = i_end_of_expr;
                    n_code = i2p_pkg::op_of(i_symbol);
                    if (i2p_pkg::is_op(i_symbol)) begin
                        n_state = i2p_pkg::S_OPER;
                    end else begin
                        n_state = i2p_pkg::S_OPERAND;
                    end
                end
            end

            i2p_pkg::S_OPERAND: begin
                // Pass the operand straight through.
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_sym   = r_sym;
                    n_out_last  = r_last && (r_count == '0);
                    n_out_ovf   = r_ovf_seen;
                    if (!r_last) begin
                        n_state = i2p_pkg::S_IDLE;
                    end else if (r_count == '0) begin
                        n_ovf_seen = 1'b0;
                        n_state    = i2p_pkg::S_IDLE;
                    end else begin
                        n_state = i2p_pkg::S_FLUSH;
                    end
                end
            end

            i2p_pkg::S_OPER: begin
                if (w_pop_cond) begin
                    // Pop one entry per cycle while the output register is free; never the final result here,
                    // since the push that follows leaves the stack non-empty.
                    if (w_slot_free) begin
                        n_out_valid = 1'b1;
                        n_out_sym   = i2p_pkg::char_of(w_top);
                        n_out_last  = 1'b0;
                        n_out_ovf   = r_ovf_seen;
                        n_count     = r_count - CW'(1);
                    end
                end else begin
                    // Push, or drop and flag when the stack is full.
                    if (w_full) begin
                        n_ovf_seen = 1'b1;
                    end else begin
                        w_we    = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                    n_state = r_last ? i2p_pkg::S_FLUSH : i2p_pkg::S_IDLE;
                end
            end

            i2p_pkg::S_FLUSH: begin
                // Drain the stack; the entry at the bottom ends the expression.
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_sym   = i2p_pkg::char_of(w_top);
                    n_out_last  = (r_count == CW'(1));
                    n_out_ovf   = r_ovf_seen;
                    n_count     = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        n_ovf_seen = 1'b0;
                        n_state    = i2p_pkg::S_IDLE;
                    end
                end
            end

            default: begin
                n_state = i2p_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= i2p_pkg::S_IDLE;
            r_count     <= '0;
            r_ovf_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf_seen  <= n_ovf_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_last     <= n_last;
        r_code     <= n_code;
        r_out_sym  <= n_out_sym;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_ready      = (r_state == i2p_pkg::S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_out_symbol = r_out_sym;
    assign o_expr_last  = r_out_last;
    assign o_overflow   = r_out_ovf;

endmodule

`default_nettype wire

@@ bench/tb_infix_to_postfix_converter.sv @@
`default_nettype none

module tb_infix_to_postfix_converter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = 16;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 6;
    localparam int MAX_GAP = 11;
    localparam int REPORT_CAP = 10;
    // Longest correct silence: sender gap + latency + receiver stall, well under this.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet cycles after the last expected beat, to catch stray results.
    localparam int END_QUIET = 24;
    localparam int EXPR_TARGET = 400;
    localparam int NOISE_BEATS = 80;

    // Operator characters indexed by stack code.
    localparam logic [7:0] OPER_CHARS [4] = '{i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS,
                                               i2p_pkg::CH_STAR, i2p_pkg::CH_SLASH};

    typedef struct packed {
        logic [7:0] sym;
        logic       last;
        logic       ovf;
    } t_postfix_beat;

    // Drive every input to a known value from time zero.
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [7:0] i_symbol      = 8'h00;
    logic       i_end_of_expr = 1'b0;
    logic       i_ready       = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_symbol;
    logic       o_expr_last;
    logic       o_overflow;

    // Shadow of the operator stack, used to predict the postfix stream.
    i2p_pkg::t_op op_stk [STACK_DEPTH];
    int unsigned  stk_cnt = 0;
    bit           ovf_seen = 1'b0;

    t_postfix_beat postfix_q [$];
    int            err_count = 0;
    int            beats_sent = 0;
    bit            no_idle = 1'b0;
    int            wd_count;

    infix_to_postfix_converter #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_symbol      (i_symbol),
        .i_end_of_expr (i_end_of_expr),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_symbol  (o_out_symbol),
        .o_expr_last   (o_expr_last),
        .o_overflow    (o_overflow)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= REPORT_CAP) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // Map a byte onto its operator code; return 0 for an operand byte.
    function automatic bit decode_operator(input logic [7:0] sym, output i2p_pkg::t_op code);
        bit found;
        found = 1'b0;
        code = i2p_pkg::OP_ADD;
        for (int k = 0; k < 4; k++) begin
            if (OPER_CHARS[k] == sym) begin
                found = 1'b1;
                code = i2p_pkg::t_op'(k);
            end
        end
        return found;
    endfunction

    // Work out the postfix beats caused by one accepted input beat and queue them.
    function automatic void predict_postfix(input logic [7:0] sym, input logic eoe);
        logic [7:0]   emitted [$];
        i2p_pkg::t_op code;
        bit           is_oper;
        is_oper = decode_operator(sym, code);
        if (!is_oper) begin
            emitted.push_back(sym);
        end else begin
            // Bit 1 of the code is the precedence: pop while top ranks equal or higher.
            while (stk_cnt > 0 && op_stk[stk_cnt - 1][1] >= code[1]) begin
                stk_cnt--;
                emitted.push_back(OPER_CHARS[op_stk[stk_cnt]]);
            end
            if (stk_cnt >= STACK_DEPTH) begin
                ovf_seen = 1'b1;
            end else begin
                op_stk[stk_cnt] = code;
                stk_cnt++;
            end
        end
        if (eoe) begin
            while (stk_cnt > 0) begin
                stk_cnt--;
                emitted.push_back(OPER_CHARS[op_stk[stk_cnt]]);
            end
        end
        foreach (emitted[k]) begin
            postfix_q.push_back('{sym: emitted[k],
                                  last: eoe && (k == emitted.size() - 1),
                                  ovf: ovf_seen});
        end
        // The sticky drop flag belongs to one expression only.
        if (eoe) begin
            ovf_seen = 1'b0;
        end
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [7:0] random_operand();
        logic [7:0]   b;
        i2p_pkg::t_op c;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (decode_operator(b, c));
        return b;
    endfunction

    // Send one beat. Valid stays high across back-to-back beats; lower it only for a gap.
    task automatic send_beat(input logic [7:0] sym, input logic eoe);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_symbol <= sym;
        i_end_of_expr <= eoe;
        do @(posedge i_clk); while (!o_ready);
        predict_postfix(sym, eoe);
        beats_sent++;
    endtask

    // Hold the sender off until every expected beat has come out.
    task automatic wait_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (postfix_q.size() != 0);
    endtask

    // Result side: stall at random, then take and check one beat.
    initial begin : postfix_checker
        t_postfix_beat exp_beat;
        int            stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (postfix_q.size() == 0) begin
                flag_error($sformatf("unexpected beat: sym=%h last=%b ovf=%b",
                                     o_out_symbol, o_expr_last, o_overflow));
            end else begin
                exp_beat = postfix_q.pop_front();
                if (o_out_symbol !== exp_beat.sym || o_expr_last !== exp_beat.last ||
                    o_overflow !== exp_beat.ovf) begin
                    flag_error($sformatf(
                        "beat mismatch: expected sym=%h last=%b ovf=%b, got sym=%h last=%b ovf=%b",
                        exp_beat.sym, exp_beat.last, exp_beat.ovf,
                        o_out_symbol, o_expr_last, o_overflow));
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles with no beat on either channel.
    initial begin : watchdog
        wd_count = 0;
        while (wd_count < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                wd_count = 0;
            end else begin
                wd_count++;
            end
        end
        $display("tb_infix_to_postfix_converter: errors");
        $finish;
    end

    // Operand bytes at the extremes and right beside the operator codes.
    task automatic test_operands();
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h2C, 1'b0);
        send_beat(8'h2E, 1'b0);
        send_beat(8'h30, 1'b0);
        send_beat(8'hAA, 1'b1);
    endtask

    // All four operators in one expression: a+b*c-d/e.
    task automatic test_precedence();
        send_beat("a", 1'b0);
        send_beat(i2p_pkg::CH_PLUS, 1'b0);
        send_beat("b", 1'b0);
        send_beat(i2p_pkg::CH_STAR, 1'b0);
        send_beat("c", 1'b0);
        send_beat(i2p_pkg::CH_MINUS, 1'b0);
        send_beat("d", 1'b0);
        send_beat(i2p_pkg::CH_SLASH, 1'b0);
        send_beat("e", 1'b1);
    endtask

    // End of expression on an operator, on an empty stack, and after operator runs.
    task automatic test_expression_end();
        send_beat("x", 1'b0);
        send_beat(i2p_pkg::CH_STAR, 1'b1);
        send_beat(i2p_pkg::CH_MINUS, 1'b1);
        send_beat(i2p_pkg::CH_PLUS, 1'b0);
        send_beat(i2p_pkg::CH_PLUS, 1'b0);
        send_beat(i2p_pkg::CH_SLASH, 1'b0);
        send_beat(i2p_pkg::CH_SLASH, 1'b1);
    endtask

    // Pause the sender with operators still stacked, then finish the expression.
    task automatic test_drain_pause();
        send_beat("p", 1'b0);
        send_beat(i2p_pkg::CH_PLUS, 1'b0);
        send_beat("q", 1'b0);
        send_beat(i2p_pkg::CH_STAR, 1'b0);
        wait_drain();
        send_beat("r", 1'b0);
        send_beat(i2p_pkg::CH_MINUS, 1'b0);
        send_beat("s", 1'b1);
    endtask

    // Well-formed expressions with random operands and operators.
    task automatic test_random_expressions();
        int n_operands;
        while (beats_sent < EXPR_TARGET) begin
            // Run about one expression in five with no idling on either side.
            no_idle = ($urandom_range(0, 4) == 0);
            n_operands = $urandom_range(1, 6);
            for (int k = 0; k < n_operands; k++) begin
                send_beat(random_operand(), k == n_operands - 1);
                if (k != n_operands - 1) begin
                    send_beat(OPER_CHARS[$urandom_range(0, 3)], 1'b0);
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                wait_drain();
            end
        end
        no_idle = 1'b0;
    endtask

    // Broken sequences: any byte, operators half the time, end flags at random.
    task automatic test_random_noise();
        logic [7:0] sym;
        for (int k = 0; k < NOISE_BEATS; k++) begin
            if ($urandom_range(0, 1) == 0) begin
                sym = OPER_CHARS[$urandom_range(0, 3)];
            end else begin
                sym = 8'($urandom_range(0, 255));
            end
            send_beat(sym, $urandom_range(0, 3) == 0);
        end
        // Close the last expression so the stack is flushed.
        send_beat(random_operand(), 1'b1);
    endtask

    initial begin : main_sequence
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_operands();
        test_precedence();
        test_expression_end();
        test_drain_pause();
        test_random_expressions();
        test_random_noise();
        wait_drain();
        repeat (END_QUIET) @(posedge i_clk);
        if (postfix_q.size() != 0) begin
            flag_error($sformatf("%0d expected beats never came out", postfix_q.size()));
        end
        if (err_count == 0) begin
            $display("tb_infix_to_postfix_converter: clean");
        end else begin
            $display("tb_infix_to_postfix_converter: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
